// File: src/tpq_pkg.sv
`timescale 1ns / 1ps

package tpq_pkg;

  // field widths
  localparam int RAW_W   = 12;
  localparam int MS_W    = 16;
  localparam int POS_W   = 9;
  localparam int CFG_I_W = 2;

  // register indexes
  localparam logic [CFG_I_W-1:0] REG_HOLD_MS   = 2'd0;
  localparam logic [CFG_I_W-1:0] REG_LANDSCAPE = 2'd1;

  // scaling constants
  localparam logic [RAW_W-1:0] X_OFFSET = 12'd340;
  localparam logic [RAW_W-1:0] Y_OFFSET = 12'd320;
  localparam logic [POS_W-1:0] X_LIMIT  = 9'd237;
  localparam logic [POS_W-1:0] Y_FULL   = 9'd320;

  // x: off*10/144 = (off*5 >> 3) / 9, and /9 is *3641 >> 15 for values below 2^15
  localparam logic [RAW_W-1:0] X_RECIP9  = 12'd3641;
  // y: /11 is *2979 >> 15 for values below 2^15
  localparam logic [RAW_W-1:0] Y_RECIP11 = 12'd2979;
  localparam int RECIP_SH = 15;

  localparam logic [MS_W-1:0] HOLD_MS_RESET = '0;

  // scaled poll, from scaler to qualifier
  typedef struct packed {
    logic             touch;
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] y_div;
  } scaled_t;

endpackage

// File: src/tpq_scaler.sv
`timescale 1ns / 1ps

module tpq_scaler (
  input  logic [tpq_pkg::RAW_W-1:0] raw_x,
  input  logic [tpq_pkg::RAW_W-1:0] raw_y,
  output tpq_pkg::scaled_t          scaled
);
  import tpq_pkg::*;

  logic             x_ok;
  logic             y_ok;
  logic [RAW_W-1:0] x_off;
  logic [RAW_W-1:0] y_off;
  logic [RAW_W+2:0] x_times5;
  logic [RAW_W-1:0] x_eighth;
  logic [2*RAW_W-1:0] x_prod;
  logic [2*RAW_W-1:0] y_prod;
  logic [POS_W-1:0] x_quot;
  logic [POS_W-1:0] y_quot;

  // offsets, below offset means no touch
  assign x_ok  = (raw_x >= X_OFFSET);
  assign y_ok  = (raw_y >= Y_OFFSET);
  assign x_off = raw_x - X_OFFSET;
  assign y_off = raw_y - Y_OFFSET;

  // x scale: off*5/72 through a divide by 8 then a reciprocal for 9
  assign x_times5 = {1'b0, x_off, 2'b00} + {3'b000, x_off};
  assign x_eighth = x_times5[RAW_W+2:3];
  assign x_prod   = {{RAW_W{1'b0}}, x_eighth} * {{RAW_W{1'b0}}, X_RECIP9};
  assign x_quot   = x_prod[RECIP_SH+POS_W-1:RECIP_SH];

  // y scale: off/11 through a reciprocal
  assign y_prod = {{RAW_W{1'b0}}, y_off} * {{RAW_W{1'b0}}, Y_RECIP11};
  assign y_quot = y_prod[RECIP_SH+POS_W-1:RECIP_SH];

  // touch when sx below its limit and sy = 320 - quotient above zero
  always_comb begin
    scaled.sx    = x_quot;
    scaled.y_div = y_quot;
    scaled.touch = x_ok && y_ok && (x_quot < X_LIMIT) && (y_quot < Y_FULL);
  end

endmodule

// File: src/tpq_qualifier.sv
`timescale 1ns / 1ps

module tpq_qualifier (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  tpq_pkg::scaled_t          scaled,
  input  logic [tpq_pkg::MS_W-1:0]  elapsed_ms,
  input  logic [tpq_pkg::MS_W-1:0]  hold_ms,
  input  logic                      landscape,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      touch_valid,
  output logic [tpq_pkg::POS_W-1:0] pos_x,
  output logic [tpq_pkg::POS_W-1:0] pos_y
);
  import tpq_pkg::*;

  logic            timer_armed;
  logic            already_reported;
  logic [MS_W-1:0] hold_elapsed;
  logic [MS_W-1:0] hold_target;

  logic            timer_armed_next;
  logic            already_reported_next;
  logic [MS_W-1:0] hold_elapsed_next;
  logic [MS_W-1:0] hold_target_next;

  logic [MS_W:0]    sum;
  logic [MS_W-1:0]  elapsed_acc;
  logic             report;
  logic [POS_W-1:0] sy;
  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;

  // saturating hold accumulation
  assign sum         = {1'b0, hold_elapsed} + {1'b0, elapsed_ms};
  assign elapsed_acc = !timer_armed ? hold_elapsed :
                       (sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0]);
  assign sy          = Y_FULL - scaled.y_div;

  // hold timer and report flag update
  always_comb begin
    timer_armed_next      = timer_armed;
    already_reported_next = already_reported;
    hold_elapsed_next     = elapsed_acc;
    hold_target_next      = hold_target;
    report                = 1'b0;
    if (scaled.touch) begin
      if (!timer_armed) begin
        timer_armed_next  = 1'b1;
        hold_elapsed_next = '0;
        hold_target_next  = hold_ms;
      end
      if ((hold_elapsed_next >= hold_target_next) && !already_reported) begin
        report                = 1'b1;
        already_reported_next = 1'b1;
      end
    end else if (timer_armed) begin
      timer_armed_next      = 1'b0;
      already_reported_next = 1'b0;
      hold_elapsed_next     = '0;
    end
  end

  // reported position, axes swapped in landscape
  always_comb begin
    px = '0;
    py = '0;
    if (report) begin
      if (landscape) begin
        px = scaled.y_div;
        py = scaled.sx;
      end else begin
        px = scaled.sx;
        py = sy;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_armed      <= 1'b0;
      already_reported <= 1'b0;
      hold_elapsed     <= '0;
      hold_target      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        timer_armed      <= timer_armed_next;
        already_reported <= already_reported_next;
        hold_elapsed     <= hold_elapsed_next;
        hold_target      <= hold_target_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      touch_valid <= report;
      pos_x       <= px;
      pos_y       <= py;
    end
  end

endmodule

// File: src/touch_press_qualifier.sv
`timescale 1ns / 1ps

// touch press qualifier
// input channel: one beat per converter poll (raw_x, raw_y, elapsed_ms) on
// in_valid / in_ready. output channel: exactly one beat per poll
// (touch_valid, pos_x, pos_y) on out_valid / out_ready; positions read zero
// when touch_valid is low, and a position is reported once per press after
// it has been held for hold_ms.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is hold_ms, index 1 is landscape (bit 0); other indexes are ignored.
// cfg_ready is always high; write only while no poll is in flight.
// the input register takes the beat; the scaling and hold logic load the
// result register once it is empty or being taken. throughput: 1 poll per
// cycle while out_ready is high; the scaling multipliers and hold update
// sit in one stage between the two registers. reset: clears the hold timer,
// report flag, landscape and both pipeline valids, and sets hold_ms to
// HOLD_MS_INIT. a stalled receiver holds the result register, and the input
// register fills behind it, so in_ready drops after one more beat.
module touch_press_qualifier #(
  parameter logic [tpq_pkg::MS_W-1:0] HOLD_MS_INIT = tpq_pkg::HOLD_MS_RESET
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tpq_pkg::RAW_W-1:0]   raw_x,
  input  logic [tpq_pkg::RAW_W-1:0]   raw_y,
  input  logic [tpq_pkg::MS_W-1:0]    elapsed_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        touch_valid,
  output logic [tpq_pkg::POS_W-1:0]   pos_x,
  output logic [tpq_pkg::POS_W-1:0]   pos_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tpq_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [tpq_pkg::MS_W-1:0]    cfg_data
);
  import tpq_pkg::*;

  logic [MS_W-1:0]  hold_ms;
  logic             landscape;
  logic             s1_valid;
  logic [RAW_W-1:0] s1_raw_x;
  logic [RAW_W-1:0] s1_raw_y;
  logic [MS_W-1:0]  s1_elapsed;
  logic             advance;
  logic             fire;
  scaled_t          scaled;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign fire      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms   <= HOLD_MS_INIT;
      landscape <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_MS:   hold_ms   <= cfg_data;
        REG_LANDSCAPE: landscape <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw_x   <= raw_x;
      s1_raw_y   <= raw_y;
      s1_elapsed <= elapsed_ms;
    end
  end

  tpq_scaler u_scaler (
    .raw_x  (s1_raw_x),
    .raw_y  (s1_raw_y),
    .scaled (scaled)
  );

  tpq_qualifier u_qualifier (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .scaled      (scaled),
    .elapsed_ms  (s1_elapsed),
    .hold_ms     (hold_ms),
    .landscape   (landscape),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .touch_valid (touch_valid),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

  // idle beat carries a zero position
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !touch_valid |-> pos_x == '0 && pos_y == '0)
    else $error("non-report beat with nonzero position");

  // reported position stays on screen
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && touch_valid |-> pos_x <= Y_FULL && pos_y <= Y_FULL)
    else $error("reported position out of range");

  // a poll in the input register moves into the result register
  a_fire_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("poll lost between stages");

  // empty result register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

// File: verif/tpq_checker.sv
`timescale 1ns / 1ps

module tpq_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tpq_pkg::RAW_W-1:0]   raw_x,
  input  logic [tpq_pkg::RAW_W-1:0]   raw_y,
  input  logic [tpq_pkg::MS_W-1:0]    elapsed_ms,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        touch_valid,
  input  logic [tpq_pkg::POS_W-1:0]   pos_x,
  input  logic [tpq_pkg::POS_W-1:0]   pos_y,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tpq_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [tpq_pkg::MS_W-1:0]    cfg_data,
  output int                          mismatches,
  output int                          outstanding
);
  import tpq_pkg::*;

  // x scale is off*10/144, y scale is off/11
  localparam int unsigned X_NUM = 10;
  localparam int unsigned X_DEN = 144;
  localparam int unsigned Y_DEN = 11;
  localparam int unsigned HOLD_MAX = 32'h0000_FFFF;

  typedef struct packed {
    logic             touch_valid;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } press_report_t;

  // shadow of the config registers
  logic [MS_W-1:0] hold_ms_reg;
  logic            landscape_reg;

  // shadow of the hold timer
  logic [MS_W-1:0] held_ms;
  logic [MS_W-1:0] held_target;
  logic            armed;
  logic            reported;

  press_report_t report_q[$];
  int            fail_cnt;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fail_cnt    = 0;
  end

  // one poll through the scaler and hold timer, returns the report beat
  function automatic press_report_t qualify_poll(input logic [RAW_W-1:0] rx,
                                                 input logic [RAW_W-1:0] ry,
                                                 input logic [MS_W-1:0]  dt);
    int unsigned   sum;
    int unsigned   sx;
    int            sy;
    logic          touch;
    press_report_t rep;
    rep   = '0;
    touch = 1'b0;
    sx    = 0;
    sy    = 0;
    // timer advances before the touch is judged, saturating
    if (armed) begin
      sum     = 32'(held_ms) + 32'(dt);
      held_ms = (sum > HOLD_MAX) ? MS_W'(HOLD_MAX) : MS_W'(sum);
    end
    // raw below either offset is no touch
    if (rx >= X_OFFSET && ry >= Y_OFFSET) begin
      sx = 32'(rx - X_OFFSET) * X_NUM / X_DEN;
      if (sx > 32'(X_LIMIT))
        sx = 32'(X_LIMIT);
      sy = int'(Y_FULL) - int'(32'(ry - Y_OFFSET) / Y_DEN);
      if (sy < 0)
        sy = 0;
      touch = (sx < 32'(X_LIMIT)) && (sy > 0);
    end
    if (touch) begin
      if (!armed) begin
        armed       = 1'b1;
        held_ms     = '0;
        held_target = hold_ms_reg;
      end
      if (held_ms >= held_target && !reported) begin
        rep.touch_valid = 1'b1;
        if (landscape_reg) begin
          rep.pos_x = Y_FULL - POS_W'(sy);
          rep.pos_y = POS_W'(sx);
        end else begin
          rep.pos_x = POS_W'(sx);
          rep.pos_y = POS_W'(sy);
        end
        reported = 1'b1;
      end
    end else if (armed) begin
      armed    = 1'b0;
      reported = 1'b0;
      held_ms  = '0;
    end
    return rep;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // watch all three channels at the clock edge
  always @(posedge clk) begin : watch
    press_report_t want;
    if (rst) begin
      hold_ms_reg   = HOLD_MS_RESET;
      landscape_reg = 1'b0;
      held_ms       = '0;
      held_target   = '0;
      armed         = 1'b0;
      reported      = 1'b0;
      report_q.delete();
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD_MS:   hold_ms_reg = cfg_data;
          REG_LANDSCAPE: landscape_reg = cfg_data[0];
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with none expected, got touch_valid=%0b pos_x=%0d pos_y=%0d",
                   $time, touch_valid, pos_x, pos_y);
        end else begin
          want = report_q.pop_front();
          check_field("touch_valid", want.touch_valid, touch_valid);
          check_field("pos_x", want.pos_x, pos_x);
          check_field("pos_y", want.pos_y, pos_y);
        end
      end
      // poll beat
      if (in_valid && in_ready)
        report_q.push_back(qualify_poll(raw_x, raw_y, elapsed_ms));
    end
    outstanding <= report_q.size();
    mismatches  <= fail_cnt;
  end

endmodule

// File: verif/touch_press_qualifier_tb.sv
`timescale 1ns / 1ps

module touch_press_qualifier_tb;
  import tpq_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 8;
  localparam int PHASE_POLLS   = 54;
  localparam logic [CFG_I_W-1:0] REG_SPARE = 2'd3;
  // last raw codes that still scale to a touch
  localparam logic [RAW_W-1:0] X_TOUCH_MAX = 12'd3752;
  localparam logic [RAW_W-1:0] Y_TOUCH_MAX = 12'd3839;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic [RAW_W-1:0]    raw_x      = '0;
  logic [RAW_W-1:0]    raw_y      = '0;
  logic [MS_W-1:0]     elapsed_ms = '0;
  logic                out_ready  = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [CFG_I_W-1:0]  cfg_index  = '0;
  logic [MS_W-1:0]     cfg_data   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                touch_valid;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic                cfg_ready;

  int                  mismatches;
  int                  outstanding;
  int                  idle_pct  = 0;
  int                  stall_pct = 0;
  logic [MS_W-1:0]     cur_hold  = HOLD_MS_RESET;

  touch_press_qualifier uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .raw_x       (raw_x),
    .raw_y       (raw_y),
    .elapsed_ms  (elapsed_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .touch_valid (touch_valid),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  tpq_checker report_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .raw_x       (raw_x),
    .raw_y       (raw_y),
    .elapsed_ms  (elapsed_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .touch_valid (touch_valid),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one poll beat, with random sender gaps ahead of it
  task automatic send_poll(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                           input logic [MS_W-1:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    raw_x      <= rx;
    raw_y      <= ry;
    elapsed_ms <= dt;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every report beat
  task automatic drain_reports(input bit settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    if (settle)
      repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [MS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_HOLD_MS)
      cur_hold = data;
  endtask

  function automatic logic [RAW_W-1:0] pick_x_touch();
    case ($urandom_range(19))
      0:       return X_OFFSET;
      1:       return X_TOUCH_MAX;
      default: return RAW_W'($urandom_range(X_TOUCH_MAX, X_OFFSET));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_y_touch();
    case ($urandom_range(19))
      0:       return Y_OFFSET;
      1:       return Y_TOUCH_MAX;
      default: return RAW_W'($urandom_range(Y_TOUCH_MAX, Y_OFFSET));
    endcase
  endfunction

  // hold steps scaled to the current hold, sometimes any 16-bit value
  function automatic logic [MS_W-1:0] pick_dt();
    if ($urandom_range(99) < 85)
      return MS_W'($urandom_range(32'(cur_hold) / 3 + 5, 0));
    return MS_W'($urandom);
  endfunction

  // a poll that scales to no touch
  task automatic send_release();
    logic [RAW_W-1:0] rx;
    logic [RAW_W-1:0] ry;
    rx = RAW_W'($urandom);
    ry = RAW_W'($urandom);
    case ($urandom_range(3))
      0: rx = RAW_W'($urandom_range(X_OFFSET - 1, 0));
      1: ry = RAW_W'($urandom_range(Y_OFFSET - 1, 0));
      2: rx = RAW_W'($urandom_range(4095, X_TOUCH_MAX + 1));
      default: ry = RAW_W'($urandom_range(4095, Y_TOUCH_MAX + 1));
    endcase
    send_poll(rx, ry, pick_dt());
  endtask

  initial begin
    int n;
    int r;
    int sent;
    logic [RAW_W-1:0] px;
    logic [RAW_W-1:0] py;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: offsets, clamps and zero hold at reset settings
    send_poll('0, '0, '0);
    send_poll(X_OFFSET - 1, 12'd2000, 16'd7);
    send_poll(12'd2000, Y_OFFSET - 1, 16'd7);
    send_poll(X_OFFSET, Y_TOUCH_MAX, '0);
    send_poll(X_OFFSET, Y_TOUCH_MAX, '1);
    send_poll(X_TOUCH_MAX + 1, Y_OFFSET, 16'd3);
    send_poll(X_TOUCH_MAX, Y_OFFSET, 16'd3);
    send_poll('1, '1, '1);
    send_poll(12'd2000, Y_TOUCH_MAX + 1, 16'd3);

    // hold rewritten mid press only applies at the next press
    drain_reports(1'b1);
    write_reg(REG_SPARE, '1);
    write_reg(REG_LANDSCAPE, 16'd1);
    write_reg(REG_HOLD_MS, 16'd100);
    send_poll(12'd1000, 12'd1000, '1);
    send_poll(12'd1000, 12'd1000, 16'd50);
    drain_reports(1'b1);
    write_reg(REG_HOLD_MS, '0);
    send_poll(12'd1000, 12'd1000, 16'd49);
    send_poll(12'd1000, 12'd1000, 16'd1);
    send_poll('0, '0, '0);

    // longest hold and timer saturation
    drain_reports(1'b1);
    write_reg(REG_HOLD_MS, '1);
    write_reg(REG_LANDSCAPE, '0);
    send_poll(12'd3000, 12'd500, 16'd123);
    send_poll(12'd3000, 12'd500, 16'd40000);
    send_poll(12'd3000, 12'd500, 16'd40000);
    send_poll(12'd3000, 12'd500, '1);
    send_poll('0, 12'd500, '0);
    send_poll(12'd600, 12'd3500, 16'd9);
    send_poll(12'd600, 12'd3500, 16'd65534);
    send_poll(12'd600, 12'd3500, 16'd1);
    send_poll(12'd600, '0, '0);

    // random presses and noise over idling and register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_reports(1'b1);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      case (ph)
        0: begin
          write_reg(REG_HOLD_MS, '0);
          write_reg(REG_LANDSCAPE, '0);
        end
        1: begin
          write_reg(REG_HOLD_MS, '1);
          write_reg(REG_LANDSCAPE, 16'd1);
        end
        default: begin
          if ($urandom_range(99) < 80)
            write_reg(REG_HOLD_MS, MS_W'($urandom_range(300, 0)));
          else
            write_reg(REG_HOLD_MS, MS_W'($urandom));
          write_reg(REG_LANDSCAPE, MS_W'($urandom_range(1)));
        end
      endcase
      sent = 0;
      while (sent < PHASE_POLLS) begin
        if ($urandom_range(99) < 75) begin
          // press held over a few polls, then up to two release polls
          n  = $urandom_range(8, 1);
          r  = $urandom_range(2);
          px = pick_x_touch();
          py = pick_y_touch();
          repeat (n) begin
            if ($urandom_range(9) == 0) begin
              px = pick_x_touch();
              py = pick_y_touch();
            end
            send_poll(px, py, pick_dt());
          end
          repeat (r) send_release();
          sent += n + r;
          if ($urandom_range(99) < 4)
            drain_reports(1'b0);
        end else begin
          send_poll(RAW_W'($urandom), RAW_W'($urandom), MS_W'($urandom));
          sent++;
        end
      end
    end

    drain_reports(1'b1);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
